/* sv/isometric_depth_order_sorter_macros.svh */
// Assertion helpers for the depth-order sorter.
`ifndef ISOMETRIC_DEPTH_ORDER_SORTER_MACROS_SVH
`define ISOMETRIC_DEPTH_ORDER_SORTER_MACROS_SVH
`ifndef SYNTHESIS
`define IDOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IDOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IDOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IDOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/idos_pkg.sv */
package idos_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int COORD_BITS = 16;
	localparam int TAG_BITS = 16;
	localparam int IDX_BITS = $clog2(MAX_ITEMS);
	localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
	localparam int ITEM_BITS = 2 * COORD_BITS + TAG_BITS;
	localparam int KEY_BITS = COORD_BITS + 1;
	localparam int ORD_BITS = KEY_BITS + COORD_BITS + IDX_BITS;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Total order: depth key, then x, then arrival index. Sign bits are flipped
	// so that an unsigned compare gives the signed order.
	function automatic logic [ORD_BITS-1:0] order_word(
		input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] y,
		input logic [IDX_BITS-1:0] idx
	);
		logic [KEY_BITS-1:0] key;
		key = {y[COORD_BITS-1], y} - {x[COORD_BITS-1], x};
		return {~key[KEY_BITS-1], key[KEY_BITS-2:0], ~x[COORD_BITS-1],
			x[COORD_BITS-2:0], idx};
	endfunction
endpackage

/* sv/idos_ram.sv */
module idos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* sv/isometric_depth_order_sorter.sv */
// Load: one beat per cycle while in the load state, into a 64-entry item memory.
// Sort: for a batch of n items, each result comes from a scan of the memory
// for the next smallest item, a pipeline drain and an emit that waits while
// the output is stalled. Each scan reads through the memory's single read
// port. Reset clears count, flags and FSM; the memory is not cleared.
`include "isometric_depth_order_sorter_macros.svh"
module isometric_depth_order_sorter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pos_x, pos_y, item_tag
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // out_x, out_y, out_tag
	output logic        m_tlast,
	output logic        m_tuser   // overflow
);
	localparam int CB = idos_pkg::COORD_BITS;
	localparam int IB = idos_pkg::IDX_BITS;
	localparam int NB = idos_pkg::CNT_BITS;
	localparam int OB = idos_pkg::ORD_BITS;
	localparam int WB = idos_pkg::ITEM_BITS;

	idos_pkg::state_t state_q, state_d;
	logic [NB-1:0] count_q;
	logic          ovf_q;
	logic [IB-1:0] scan_q;
	logic [NB-1:0] rank_q;
	logic          first_q;
	logic [OB-1:0] prev_q;
	logic [OB-1:0] best_q;
	logic [WB-1:0] best_data_q;
	logic          found_q;
	logic          valid_s1;
	logic [IB-1:0] idx_s1;
	logic [WB-1:0] rdata;
	logic [OB-1:0] cand;
	logic          take;
	logic          in_acc;
	logic          can_store;
	logic          rd_en;
	logic          emit_go;
	logic          last_rank;
	logic          scan_end;

	assign in_acc = s_tvalid && s_tready;
	assign can_store = count_q < NB'(idos_pkg::MAX_ITEMS);
	assign scan_end = ({1'b0, scan_q} + NB'(1)) == count_q;
	assign last_rank = (rank_q + NB'(1)) == count_q;

	idos_ram #(.WIDTH(WB), .DEPTH(idos_pkg::MAX_ITEMS)) u_ram (
		.clk   (clk),
		.we    (in_acc && can_store),
		.waddr (count_q[IB-1:0]),
		.wdata (s_tdata[WB-1:0]),
		.re    (rd_en),
		.raddr (scan_q),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idos_pkg::ST_LOAD:  if (in_acc && s_tlast) state_d = idos_pkg::ST_SCAN;
			idos_pkg::ST_SCAN:  if (scan_end) state_d = idos_pkg::ST_DRAIN;
			idos_pkg::ST_DRAIN: state_d = idos_pkg::ST_EMIT;
			idos_pkg::ST_EMIT: begin
				if (emit_go) state_d = last_rank ? idos_pkg::ST_LOAD : idos_pkg::ST_SCAN;
			end
			default: state_d = idos_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en = 1'b0;
		emit_go = 1'b0;
		unique case (state_q)
			idos_pkg::ST_LOAD: s_tready = 1'b1;
			idos_pkg::ST_SCAN: rd_en = 1'b1;
			idos_pkg::ST_DRAIN: ;
			idos_pkg::ST_EMIT: emit_go = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	assign cand = idos_pkg::order_word(rdata[CB-1:0], rdata[2*CB-1:CB], idx_s1);
	assign take = valid_s1 && (first_q || cand > prev_q) && (!found_q || cand < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idos_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			scan_q <= '0;
			rank_q <= '0;
			first_q <= 1'b1;
			found_q <= 1'b0;
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_s1 <= rd_en;
			if (in_acc) begin
				if (can_store) count_q <= count_q + NB'(1);
				else ovf_q <= 1'b1;
			end
			if (rd_en) scan_q <= scan_end ? '0 : scan_q + IB'(1);
			if (take) found_q <= 1'b1;
			if (emit_go) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (emit_go) begin
				found_q <= 1'b0;
				first_q <= last_rank;
				if (last_rank) begin
					rank_q <= '0;
					count_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					rank_q <= rank_q + NB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (take) begin
			best_q <= cand;
			best_data_q <= rdata;
		end
		if (emit_go) begin
			prev_q <= best_q;
			m_tdata <= best_data_q;
			m_tlast <= last_rank;
			m_tuser <= ovf_q;
		end
	end

	`IDOS_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, count_q <= NB'(idos_pkg::MAX_ITEMS))
	`IDOS_ASSERT_IMPL(a_emit_found, clk, arst_n, emit_go, found_q)
	`IDOS_ASSERT_IMPL(a_rank_range, clk, arst_n, state_q != idos_pkg::ST_LOAD, rank_q < count_q)
	`IDOS_ASSERT_NEXT(a_batch_reset, clk, arst_n, emit_go && last_rank, count_q == '0 && !ovf_q)
endmodule
